@@ sv/mbba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbba_pkg
// Shared widths, state encoding and controller/datapath interface types for
// the multi-block bump allocator.
// ----------------------------------------------------------------------------
package mbba_pkg;

   // block table
   localparam int MAX_BLOCKS = 16;
   localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

   // field widths
   localparam int BYTES_W = 24;
   localparam int ALIGN_W = 13;
   localparam int OFF_W   = 26;
   localparam int MIN_W   = 25;
   localparam int TALLY_W = 40;

   // smallest capacity of a new block, whatever the register holds
   localparam logic [MIN_W-1:0] FLOOR_BLOCK_BYTES = MIN_W'(1024);
   localparam logic [MIN_W-1:0] MIN_BLOCK_RESET   = MIN_W'(4096);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_MIN_BLOCK = 1'b0;

   // operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_RESET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;         // latch the request, start scan at current block
      logic clear_all;    // reset request: empty every block
      logic step;         // move scan to the next block
      logic commit_hit;   // place item in the block under scan
      logic commit_new;   // open a new block for the item
      logic commit_fail;  // table full, nothing fits
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_reset;
      logic fit;
      logic scan_done;
      logic table_full;
   } status_type;

endpackage
`default_nettype wire

@@ sv/mbba_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbba_ctrl
// Sequencer: accepts an item, walks the block table one block per cycle,
// then commits a hit, a new block or a failure and holds the result.
// ----------------------------------------------------------------------------
module mbba_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   input  wire mbba_pkg::status_type status,
   output mbba_pkg::cmd_type   cmd
);

   mbba_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         mbba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.req_is_reset) begin
                  cmd.clear_all = 1'b1;
                  state_in      = mbba_pkg::ST_DONE;
               end else begin
                  state_in = mbba_pkg::ST_SCAN;
               end
            end
         end
         mbba_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = mbba_pkg::ST_DECIDE;
            end else if (status.fit) begin
               cmd.commit_hit = 1'b1;
               state_in       = mbba_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         mbba_pkg::ST_DECIDE: begin
            if (status.table_full) begin
               cmd.commit_fail = 1'b1;
            end else begin
               cmd.commit_new = 1'b1;
            end
            state_in = mbba_pkg::ST_DONE;
         end
         mbba_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = mbba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbba_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ sv/mbba_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbba_dp
// Block table, scan pointer, fit check, new block sizing, live tally,
// minimum block register and the result registers.
// ----------------------------------------------------------------------------
module mbba_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   // configuration
   input  wire                                  min_wr,
   input  wire  [mbba_pkg::MIN_W-1:0]           min_wdata,
   output logic [mbba_pkg::MIN_W-1:0]           min_block_bytes,
   // request fields
   input  wire                                  req_func,
   input  wire  [mbba_pkg::BYTES_W-1:0]         req_req_bytes,
   input  wire  [mbba_pkg::ALIGN_W-1:0]         req_align,
   // control
   input  wire mbba_pkg::cmd_type               cmd,
   output mbba_pkg::status_type                 status,
   // result fields
   output logic [3:0]                           rsp_block_index,
   output logic [mbba_pkg::OFF_W-1:0]           rsp_offset,
   output logic                                 rsp_new_block,
   output logic [mbba_pkg::OFF_W-1:0]           rsp_new_block_bytes,
   output logic                                 rsp_fail,
   output logic [mbba_pkg::TALLY_W-1:0]         rsp_live_total
);

   localparam int NB     = mbba_pkg::MAX_BLOCKS;
   localparam int IW     = mbba_pkg::IDX_W;
   localparam int CW     = mbba_pkg::CNT_W;
   localparam int BW     = mbba_pkg::BYTES_W;
   localparam int AW     = mbba_pkg::ALIGN_W;
   localparam int OW     = mbba_pkg::OFF_W;
   localparam int MW     = mbba_pkg::MIN_W;
   localparam int TW     = mbba_pkg::TALLY_W;

   // block table and bookkeeping
   logic [OW-1:0] fill_ff [NB];
   logic [OW-1:0] cap_ff  [NB];
   logic [CW-1:0] count_ff;
   logic [IW-1:0] current_ff;
   logic [TW-1:0] tally_ff;
   logic [MW-1:0] min_ff;

   // latched request and scan pointer
   logic [BW-1:0] bytes_ff;
   logic [AW-1:0] align_ff;
   logic [IW-1:0] scan_k_ff;
   logic [CW-1:0] scan_n_ff;

   // result registers
   logic [3:0]    idx_ff;
   logic [OW-1:0] off_ff;
   logic          nb_ff;
   logic [OW-1:0] nbb_ff;
   logic          fail_ff;
   logic [TW-1:0] live_ff;

   logic [BW-1:0] bytes_eff;
   logic [OW-1:0] fill_k;
   logic [OW-1:0] cap_k;
   logic [AW-1:0] mask;
   logic [OW:0]   al_sum;
   logic [OW:0]   al;
   logic [OW+1:0] need;
   logic          fit;
   logic [IW-1:0] scan_k_next;
   logic [MW-1:0] base;
   logic [MW-1:0] need_new;
   logic [OW-1:0] new_cap;
   logic [TW:0]   tally_sum;
   logic [TW-1:0] tally_next;
   logic [IW-1:0] new_idx;

   // zero bytes count as one
   assign bytes_eff = (req_req_bytes == '0) ? BW'(1) : req_req_bytes;

   // fit check on the block under scan: round fill up, add bytes, compare
   assign fill_k = fill_ff[scan_k_ff];
   assign cap_k  = cap_ff[scan_k_ff];
   assign mask   = align_ff - AW'(1);
   assign al_sum = {1'b0, fill_k} + (OW + 1)'(mask);
   assign al     = (align_ff == '0) ? {1'b0, fill_k} : (al_sum & ~((OW + 1)'(mask)));
   assign need   = {1'b0, al} + (OW + 2)'(bytes_ff);
   assign fit    = need <= (OW + 2)'(cap_k);

   // round-robin wrap over the open blocks
   assign scan_k_next = ({1'b0, scan_k_ff} == CW'(count_ff - CW'(1))) ? '0
                                                                       : scan_k_ff + IW'(1);

   // capacity of a new block
   assign base     = (min_ff < mbba_pkg::FLOOR_BLOCK_BYTES) ? mbba_pkg::FLOOR_BLOCK_BYTES
                                                             : min_ff;
   assign need_new = MW'(bytes_ff) + MW'(align_ff);
   assign new_cap  = (base > need_new) ? OW'(base) : OW'(need_new);
   assign new_idx  = count_ff[IW-1:0];

   // saturating live tally
   assign tally_sum  = {1'b0, tally_ff} + (TW + 1)'(bytes_ff);
   assign tally_next = tally_sum[TW] ? {TW{1'b1}} : tally_sum[TW-1:0];

   assign status.req_is_reset = (req_func == mbba_pkg::FUNC_RESET);
   assign status.fit          = fit;
   assign status.scan_done    = (scan_n_ff == count_ff);
   assign status.table_full   = (count_ff == CW'(NB));

   // minimum block size register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= mbba_pkg::MIN_BLOCK_RESET;
      end else if (min_wr) begin
         min_ff <= min_wdata;
      end
   end

   // allocator state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         current_ff <= '0;
         tally_ff   <= '0;
         for (int i = 0; i < NB; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (cmd.clear_all) begin
         current_ff <= '0;
         tally_ff   <= '0;
         for (int i = 0; i < NB; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (cmd.commit_hit) begin
         current_ff          <= scan_k_ff;
         fill_ff[scan_k_ff]  <= need[OW-1:0];
         tally_ff            <= tally_next;
      end else if (cmd.commit_new) begin
         count_ff           <= count_ff + CW'(1);
         current_ff         <= new_idx;
         fill_ff[new_idx]   <= OW'(bytes_ff);
         tally_ff           <= tally_next;
      end
   end

   // capacities: written only when a block opens
   always_ff @(posedge clock) begin
      if (cmd.commit_new) begin
         cap_ff[new_idx] <= new_cap;
      end
   end

   // request latch and scan pointer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bytes_ff  <= bytes_eff;
         align_ff  <= req_align;
         scan_k_ff <= current_ff;
         scan_n_ff <= '0;
      end else if (cmd.step) begin
         scan_k_ff <= scan_k_next;
         scan_n_ff <= scan_n_ff + CW'(1);
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.clear_all) begin
         idx_ff  <= '0;
         off_ff  <= '0;
         nb_ff   <= 1'b0;
         nbb_ff  <= '0;
         fail_ff <= 1'b0;
         live_ff <= '0;
      end else if (cmd.commit_hit) begin
         idx_ff  <= 4'(scan_k_ff);
         off_ff  <= al[OW-1:0];
         nb_ff   <= 1'b0;
         nbb_ff  <= '0;
         fail_ff <= 1'b0;
         live_ff <= tally_next;
      end else if (cmd.commit_new) begin
         idx_ff  <= 4'(new_idx);
         off_ff  <= '0;
         nb_ff   <= 1'b1;
         nbb_ff  <= new_cap;
         fail_ff <= 1'b0;
         live_ff <= tally_next;
      end else if (cmd.commit_fail) begin
         idx_ff  <= '0;
         off_ff  <= '0;
         nb_ff   <= 1'b0;
         nbb_ff  <= '0;
         fail_ff <= 1'b1;
         live_ff <= tally_ff;
      end
   end

   assign min_block_bytes     = min_ff;
   assign rsp_block_index     = idx_ff;
   assign rsp_offset          = off_ff;
   assign rsp_new_block       = nb_ff;
   assign rsp_new_block_bytes = nbb_ff;
   assign rsp_fail            = fail_ff;
   assign rsp_live_total      = live_ff;

endmodule
`default_nettype wire

@@ sv/multi_block_bump_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_block_bump_allocator
// Arena bump allocator over a table of up to 16 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel (valid/ready): req_func selects
//   allocate or reset-all, req_req_bytes and req_align give size and
//   alignment. One result item per request leaves on the rsp_ channel.
//   The minimum capacity of a new block is set through the csr_ port
//   (register 0 at byte address 0); write it only while the block is idle.
// Sequence:
//   A reset request goes straight to the result state. An allocate checks
//   one open block per cycle round-robin from the current block and commits
//   as soon as one fits; a miss over every open block ends the scan, then a
//   decide state commits a new block or a failure. One item in flight;
//   req_ready returns the cycle after the result is taken.
// Reset:
//   Synchronous reset empties the table, clears the live tally and loads
//   4096 into the minimum block register.
// Stalls:
//   The result is held in registers until rsp_ready; no new item is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module multi_block_bump_allocator (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire                                  req_func,
   input  wire  [mbba_pkg::BYTES_W-1:0]         req_req_bytes,
   input  wire  [mbba_pkg::ALIGN_W-1:0]         req_align,
   // result channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [3:0]                           rsp_block_index,
   output logic [mbba_pkg::OFF_W-1:0]           rsp_offset,
   output logic                                 rsp_new_block,
   output logic [mbba_pkg::OFF_W-1:0]           rsp_new_block_bytes,
   output logic                                 rsp_fail,
   output logic [mbba_pkg::TALLY_W-1:0]         rsp_live_total,
   // configuration port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [mbba_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [mbba_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mbba_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   mbba_pkg::cmd_type           cmd;
   mbba_pkg::status_type        status;
   logic                        min_wr;
   logic                        csr_hit_min;
   logic [mbba_pkg::MIN_W-1:0]  min_block_bytes;

   // register decode: one word register at address 0
   assign csr_pready  = 1'b1;
   assign csr_hit_min = (csr_paddr[2] == mbba_pkg::CSR_IDX_MIN_BLOCK);
   assign min_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready & csr_hit_min;
   assign csr_prdata  = csr_hit_min ? mbba_pkg::CSR_DATA_W'(min_block_bytes) : '0;

   mbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbba_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .min_wr              (min_wr),
      .min_wdata           (csr_pwdata[mbba_pkg::MIN_W-1:0]),
      .min_block_bytes     (min_block_bytes),
      .req_func            (req_func),
      .req_req_bytes       (req_req_bytes),
      .req_align           (req_align),
      .cmd                 (cmd),
      .status              (status),
      .rsp_block_index     (rsp_block_index),
      .rsp_offset          (rsp_offset),
      .rsp_new_block       (rsp_new_block),
      .rsp_new_block_bytes (rsp_new_block_bytes),
      .rsp_fail            (rsp_fail),
      .rsp_live_total      (rsp_live_total)
   );

endmodule
`default_nettype wire

@@ dv/multi_block_bump_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_block_bump_allocator_tb
// Self-checking bench for the multi-block bump allocator. A queue-fed driver
// offers allocate and reset-all items with random gaps. A monitor takes the
// results under random back-pressure and checks each one against a
// behavioural model of the block table that runs as items are accepted.
// The minimum block size is reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module multi_block_bump_allocator_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 400;
   localparam logic [mbba_pkg::CSR_ADDR_W-1:0] ADDR_MIN_BLOCK =
      mbba_pkg::CSR_ADDR_W'(mbba_pkg::CSR_IDX_MIN_BLOCK) << 2;
   localparam logic [mbba_pkg::TALLY_W-1:0] TALLY_MAX = '1;

   typedef struct {
      logic                         func;
      logic [mbba_pkg::BYTES_W-1:0] nbytes;
      logic [mbba_pkg::ALIGN_W-1:0] align;
   } alloc_req_type;

   typedef struct packed {
      logic [3:0]                   block_index;
      logic [mbba_pkg::OFF_W-1:0]   offset;
      logic                         new_block;
      logic [mbba_pkg::OFF_W-1:0]   new_block_bytes;
      logic                         fail;
      logic [mbba_pkg::TALLY_W-1:0] live_total;
   } alloc_rsp_type;

   // DUT connections
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_func = mbba_pkg::FUNC_ALLOC;
   logic [mbba_pkg::BYTES_W-1:0]    req_req_bytes = '0;
   logic [mbba_pkg::ALIGN_W-1:0]    req_align = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [3:0]                      rsp_block_index;
   logic [mbba_pkg::OFF_W-1:0]      rsp_offset;
   logic                            rsp_new_block;
   logic [mbba_pkg::OFF_W-1:0]      rsp_new_block_bytes;
   logic                            rsp_fail;
   logic [mbba_pkg::TALLY_W-1:0]    rsp_live_total;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [mbba_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [mbba_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mbba_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // model of the block table
   logic [mbba_pkg::OFF_W-1:0]   blk_fill [mbba_pkg::MAX_BLOCKS];
   logic [mbba_pkg::OFF_W-1:0]   blk_cap  [mbba_pkg::MAX_BLOCKS];
   int unsigned                  blk_count = 0;
   int unsigned                  cur_blk = 0;
   logic [mbba_pkg::TALLY_W-1:0] live_tally = '0;
   logic [mbba_pkg::MIN_W-1:0]   min_block_cfg = mbba_pkg::MIN_BLOCK_RESET;

   // bench bookkeeping
   alloc_req_type  req_backlog[$];
   alloc_rsp_type  due_placements[$];
   bit          req_taken = 1'b0;
   bit          quiet_mode = 1'b0;
   bit          long_hold_done = 1'b0;
   int          req_gap_left = 0;
   int          rsp_gap_left = 0;
   int          long_hold_left = 0;
   int          rsp_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   multi_block_bump_allocator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_req_bytes       (req_req_bytes),
      .req_align           (req_align),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_block_index     (rsp_block_index),
      .rsp_offset          (rsp_offset),
      .rsp_new_block       (rsp_new_block),
      .rsp_new_block_bytes (rsp_new_block_bytes),
      .rsp_fail            (rsp_fail),
      .rsp_live_total      (rsp_live_total),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // place one item in the table model and return the result it should give
   function automatic alloc_rsp_type place_request(alloc_req_type rq);
      alloc_rsp_type rs;
      logic [63:0] nbytes;
      logic [63:0] algn;
      logic [63:0] cand;
      logic [63:0] aligned;
      logic [63:0] base;
      logic [63:0] need;
      logic [63:0] cap;
      logic [63:0] fill_new;
      int unsigned k;
      int unsigned pick;
      bit          found;
      rs = '0;
      if (rq.func == mbba_pkg::FUNC_RESET) begin
         // empty every block, keep capacities and count
         foreach (blk_fill[i]) blk_fill[i] = '0;
         cur_blk = 0;
         live_tally = '0;
      end else begin
         nbytes = (rq.nbytes == '0) ? 64'd1 : 64'(rq.nbytes);
         algn = 64'(rq.align);
         found = 1'b0;
         pick = 0;
         aligned = '0;
         // round-robin scan from the current block
         for (int unsigned i = 0; i < blk_count && !found; i++) begin
            k = (cur_blk + i) % blk_count;
            cand = 64'(blk_fill[k]);
            if (algn != 0) cand = (cand + algn - 1) & ~(algn - 1);
            if (cand + nbytes <= 64'(blk_cap[k])) begin
               found = 1'b1;
               pick = k;
               aligned = cand;
            end
         end
         // nothing fits: open a fresh block if the table has room
         if (!found && blk_count < mbba_pkg::MAX_BLOCKS) begin
            base = (min_block_cfg < mbba_pkg::FLOOR_BLOCK_BYTES)
                   ? 64'(mbba_pkg::FLOOR_BLOCK_BYTES) : 64'(min_block_cfg);
            need = nbytes + algn;
            cap = (base > need) ? base : need;
            pick = blk_count;
            blk_cap[pick] = cap[mbba_pkg::OFF_W-1:0];
            blk_count++;
            aligned = '0;
            found = 1'b1;
            rs.new_block = 1'b1;
            rs.new_block_bytes = cap[mbba_pkg::OFF_W-1:0];
         end
         if (found) begin
            cur_blk = pick;
            fill_new = aligned + nbytes;
            blk_fill[pick] = fill_new[mbba_pkg::OFF_W-1:0];
            if (64'(TALLY_MAX - live_tally) < nbytes) live_tally = TALLY_MAX;
            else live_tally = live_tally + nbytes[mbba_pkg::TALLY_W-1:0];
            rs.block_index = 4'(pick);
            rs.offset = aligned[mbba_pkg::OFF_W-1:0];
         end else begin
            rs.fail = 1'b1;
         end
      end
      rs.live_total = live_tally;
      return rs;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
   endtask

   // request driver: presents the oldest pending item, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (!quiet_mode && req_backlog.size() != 0 && $urandom_range(0, 7) == 0) begin
            req_gap_left = int'($urandom_range(0, 5));
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_func      <= req_backlog[0].func;
            req_req_bytes <= req_backlog[0].nbytes;
            req_align     <= req_backlog[0].align;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted item: predict its result
   always @(posedge clock) begin
      alloc_req_type taken;
      alloc_rsp_type placed;
      if (!reset && req_valid && req_ready) begin
         taken.func   = req_func;
         taken.nbytes = req_req_bytes;
         taken.align  = req_align;
         placed = place_request(taken);
         due_placements = {due_placements, placed};
         void'(req_backlog.pop_front());
         req_taken = 1'b1;
      end
   end

   // result receiver back-pressure, one long hold-off part way through
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_ready <= 1'b0;
      end else if (!long_hold_done && rsp_count >= 120) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         rsp_gap_left = int'($urandom_range(0, 5));
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      alloc_rsp_type got;
      alloc_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         got.block_index     = rsp_block_index;
         got.offset          = rsp_offset;
         got.new_block       = rsp_new_block;
         got.new_block_bytes = rsp_new_block_bytes;
         got.fail            = rsp_fail;
         got.live_total      = rsp_live_total;
         if (due_placements.size() == 0) begin
            note_mismatch($sformatf("result %0d with no item outstanding", rsp_count));
         end else begin
            want = due_placements.pop_front();
            if (got !== want)
               note_mismatch({
                  $sformatf("result %0d: exp idx=%0d off=%0d nb=%0d nbb=%0d fail=%0d live=%0d,",
                            rsp_count, want.block_index, want.offset, want.new_block,
                            want.new_block_bytes, want.fail, want.live_total),
                  $sformatf(" got idx=%0d off=%0d nb=%0d nbb=%0d fail=%0d live=%0d",
                            got.block_index, got.offset, got.new_block,
                            got.new_block_bytes, got.fail, got.live_total)});
         end
      end
   end

   task automatic push_req(input logic func, input logic [mbba_pkg::BYTES_W-1:0] nbytes,
                           input logic [mbba_pkg::ALIGN_W-1:0] align);
      alloc_req_type rq;
      rq.func = func;
      rq.nbytes = nbytes;
      rq.align = align;
      req_backlog = {req_backlog, rq};
   endtask

   // hold the sender until every item has been answered and the block is idle
   task automatic wait_idle();
      while (req_backlog.size() != 0 || due_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one APB transfer to the minimum block register
   task automatic csr_xfer(input bit is_write, input logic [mbba_pkg::CSR_DATA_W-1:0] wdata,
                           output logic [mbba_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= ADDR_MIN_BLOCK;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_min_block(input logic [mbba_pkg::MIN_W-1:0] want);
      logic [mbba_pkg::CSR_DATA_W-1:0] rd;
      csr_xfer(1'b0, '0, rd);
      if (rd !== mbba_pkg::CSR_DATA_W'(want))
         note_mismatch($sformatf("min_block_bytes read: exp %0d, got %0d", want, rd));
   endtask

   task automatic set_min_block(input logic [mbba_pkg::MIN_W-1:0] value);
      logic [mbba_pkg::CSR_DATA_W-1:0] rd;
      wait_idle();
      csr_xfer(1'b1, mbba_pkg::CSR_DATA_W'(value), rd);
      min_block_cfg = value;
      check_min_block(value);
   endtask

   // random items; big_pct sets how often a request needs a block of its own
   task automatic queue_random(input int count, input int big_pct);
      int                           sel;
      logic [mbba_pkg::BYTES_W-1:0] nbytes;
      logic [mbba_pkg::ALIGN_W-1:0] align;
      for (int n = 0; n < count; n++) begin
         sel = int'($urandom_range(0, 9));
         if (sel == 0) align = '0;
         else if (sel <= 7) align = mbba_pkg::ALIGN_W'(1) << $urandom_range(0, 12);
         else align = mbba_pkg::ALIGN_W'($urandom);
         if ($urandom_range(0, 99) < 5) begin
            // reset-all, payload fields are don't-care
            push_req(mbba_pkg::FUNC_RESET, mbba_pkg::BYTES_W'($urandom), align);
         end else begin
            sel = int'($urandom_range(0, 99));
            if (sel < big_pct)
               nbytes = mbba_pkg::BYTES_W'($urandom_range(24'h100000, 24'hFFFFFF));
            else if (sel < big_pct + 4) nbytes = '0;
            else if (sel < 70) nbytes = mbba_pkg::BYTES_W'($urandom_range(1, 256));
            else nbytes = mbba_pkg::BYTES_W'($urandom_range(257, 8192));
            push_req(mbba_pkg::FUNC_ALLOC, nbytes, align);
         end
      end
   endtask

   // stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      check_min_block(mbba_pkg::MIN_BLOCK_RESET);

      // directed: zero size, alignment extremes and odd masks, huge sizes,
      // reset-all with junk fields, bit patterns in the size field
      push_req(mbba_pkg::FUNC_ALLOC, 24'd0, 13'd0);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd1, 13'd1);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd100, 13'd3);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd7, 13'd4096);
      push_req(mbba_pkg::FUNC_ALLOC, 24'hFFFFFF, 13'd4096);
      push_req(mbba_pkg::FUNC_ALLOC, 24'hFFFFFF, 13'd0);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd10, 13'h1FFF);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd5, 13'h0AAA);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd5, 13'h1555);
      push_req(mbba_pkg::FUNC_RESET, 24'hFFFFFF, 13'h1FFF);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd4000, 13'd16);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd200, 13'd2);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd1, 13'd4096);
      push_req(mbba_pkg::FUNC_RESET, 24'd0, 13'd0);
      push_req(mbba_pkg::FUNC_ALLOC, 24'h800000, 13'd2048);
      push_req(mbba_pkg::FUNC_ALLOC, 24'h555555, 13'd64);
      push_req(mbba_pkg::FUNC_ALLOC, 24'hAAAAAA, 13'd32);
      push_req(mbba_pkg::FUNC_ALLOC, 24'd3000, 13'd0);

      // random phases over several minimum block sizes
      set_min_block(25'd0);
      queue_random(75, 3);
      set_min_block(25'd1024);
      queue_random(75, 3);
      set_min_block(25'h1FFFFFF);
      queue_random(75, 3);
      set_min_block(25'd16777216);
      queue_random(75, 5);
      set_min_block(25'd1500);
      queue_random(75, 15);
      set_min_block(mbba_pkg::MIN_BLOCK_RESET);
      quiet_mode = 1'b1;
      queue_random(75, 15);

      wait_idle();
      if (mismatches == 0 && due_placements.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
